// ===== rtl/pcs_pkg.sv =====
// Shared types and constants for the printhead carriage sequencer.
package pcs_pkg;

    // Machine state codes as reported on the result port.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_FEED   = 3'd2;
    localparam logic [2:0] ST_HALT   = 3'd3;
    localparam logic [2:0] ST_RETURN = 3'd4;

    // Bit positions inside the request flag word.
    localparam int FLAG_WIDTH = 7;
    localparam int F_MEDIA    = 6;
    localparam int F_INK      = 5;
    localparam int F_COVER    = 4;
    localparam int F_STOP     = 3;
    localparam int F_START    = 2;
    localparam int F_LEFT     = 1;
    localparam int F_RIGHT    = 0;

    // Flags that halt the machine.
    localparam logic [FLAG_WIDTH-1:0] FAULT_FLAGS = 7'b111_1000;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LINES_PER_JOB = 2'd0;
    localparam logic [1:0] CFG_TRAVEL_MAX    = 2'd1;
    localparam logic [1:0] CFG_FEED_PER_LINE = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [7:0] LINES_PER_JOB_RST = 8'd3;
    localparam logic [7:0] TRAVEL_MAX_RST    = 8'd5;
    localparam logic [7:0] FEED_PER_LINE_RST = 8'd5;

    // One tick of button events and sensor levels.
    typedef struct packed {
        logic start_press;
        logic stop_press;
        logic cover_toggle;
        logic ink_low;
        logic media_empty;
    } t_events;

    // Current configuration.
    typedef struct packed {
        logic [7:0] lines_per_job;
        logic [7:0] travel_max;
        logic [7:0] feed_per_line;
    } t_cfg;

endpackage

// ===== rtl/pcs_step.sv =====
// Next-state logic for one sequencer tick.
module pcs_step
    import pcs_pkg::*;
#(
    parameter int COUNT_WIDTH = 8
) (
    input  t_events                 i_events,
    input  t_cfg                    i_cfg,
    input  logic [2:0]              i_state,
    input  logic [7:0]              i_pos,
    input  logic [COUNT_WIDTH-1:0]  i_feed,
    input  logic [COUNT_WIDTH-1:0]  i_printed,
    input  logic [COUNT_WIDTH-1:0]  i_total,
    input  logic [FLAG_WIDTH-1:0]   i_flags,
    output logic [2:0]              o_state,
    output logic [7:0]              o_pos,
    output logic [COUNT_WIDTH-1:0]  o_feed,
    output logic [COUNT_WIDTH-1:0]  o_printed,
    output logic [COUNT_WIDTH-1:0]  o_total,
    output logic [FLAG_WIDTH-1:0]   o_flags,
    output logic                    o_done
);

    // Width wide enough to compare a counter with an 8-bit register.
    localparam int CMP_WIDTH = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;

    logic [FLAG_WIDTH-1:0] merged;
    logic                  left;
    logic                  right;
    logic [2:0]            cur_state;
    logic                  feed_full;

    // Merge events and levels, then derive the end sensors.
    always_comb begin
        merged = i_flags;
        if (i_events.start_press) merged[F_START] = 1'b1;
        if (i_events.stop_press) merged[F_STOP] = 1'b1;
        if (i_events.cover_toggle) merged[F_COVER] = ~merged[F_COVER];
        merged[F_INK]   = i_events.ink_low;
        merged[F_MEDIA] = i_events.media_empty;
        left  = (i_pos == 8'd0);
        right = (i_pos >= i_cfg.travel_max);
        merged[F_LEFT]  = left;
        merged[F_RIGHT] = right;
    end

    assign feed_full = (CMP_WIDTH'(i_feed) >= CMP_WIDTH'(i_cfg.feed_per_line));

    // Error check, then one step of the sequencer.
    always_comb begin
        o_flags   = merged;
        cur_state = i_state;
        o_state   = i_state;
        o_pos     = i_pos;
        o_feed    = i_feed;
        o_printed = i_printed;
        o_total   = i_total;
        o_done    = 1'b0;

        if ((merged & FAULT_FLAGS) != '0) begin
            o_flags[F_STOP]  = 1'b0;
            o_flags[F_START] = 1'b0;
            cur_state        = ST_HALT;
            o_state          = ST_HALT;
        end

        case (cur_state)
            ST_IDLE: begin
                if (o_flags[F_START]) begin
                    o_total          = COUNT_WIDTH'(i_cfg.lines_per_job);
                    o_printed        = '0;
                    o_flags[F_START] = 1'b0;
                    if (left) begin
                        o_feed  = '0;
                        o_state = ST_FEED;
                    end else begin
                        o_state = ST_RETURN;
                    end
                end
            end
            ST_SCAN: begin
                if (right) begin
                    if (i_printed != '1) o_printed = i_printed + 1'b1;
                    o_state = ST_RETURN;
                end else if (i_pos != 8'hFF) begin
                    o_pos = i_pos + 8'd1;
                end
            end
            ST_FEED: begin
                if (feed_full) begin
                    o_state = ST_SCAN;
                end else if (i_feed != '1) begin
                    o_feed = i_feed + 1'b1;
                end
            end
            ST_HALT: begin
                if ((o_flags & FAULT_FLAGS) == '0) o_state = ST_IDLE;
            end
            ST_RETURN: begin
                if (left) begin
                    if (i_total > i_printed) begin
                        o_feed  = '0;
                        o_state = ST_FEED;
                    end else begin
                        o_done  = 1'b1;
                        o_state = ST_IDLE;
                    end
                end else begin
                    o_pos = i_pos - 8'd1;
                end
            end
            default: begin
                o_state = cur_state;
            end
        endcase
    end

endmodule

// ===== rtl/printhead_carriage_sequencer_core.sv =====
// A request passes through the input register, then the step logic into the
// result register, which loads only when it is empty or being drained.
// Throughput: one request per cycle while i_ready holds; the step logic is a single pass.
// Reset (synchronous, active low) returns the machine to idle, clears the
// position, counters and flags, and restores the register defaults 3, 5, 5.
// Top level of the printhead carriage sequencer.
module printhead_carriage_sequencer_core
    import pcs_pkg::*;
#(
    parameter int COUNT_WIDTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    // Request channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_start_press,
    input  logic        i_stop_press,
    input  logic        i_cover_toggle,
    input  logic        i_ink_low,
    input  logic        i_media_empty,
    // Result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_state_code,
    output logic [7:0]  o_position_out,
    output logic [7:0]  o_feed_out,
    output logic [7:0]  o_printed_out,
    output logic [7:0]  o_total_out,
    output logic [6:0]  o_flags_out,
    output logic        o_job_done
);

    t_cfg                    r_cfg;
    logic                    r_in_valid;
    t_events                 r_events;
    logic [2:0]              r_state;
    logic [7:0]              r_pos;
    logic [COUNT_WIDTH-1:0]  r_feed;
    logic [COUNT_WIDTH-1:0]  r_printed;
    logic [COUNT_WIDTH-1:0]  r_total;
    logic [FLAG_WIDTH-1:0]   r_flags;
    logic                    r_out_valid;

    logic [2:0]              n_state;
    logic [7:0]              n_pos;
    logic [COUNT_WIDTH-1:0]  n_feed;
    logic [COUNT_WIDTH-1:0]  n_printed;
    logic [COUNT_WIDTH-1:0]  n_total;
    logic [FLAG_WIDTH-1:0]   n_flags;
    logic                    n_done;

    logic                    step_load;
    logic                    in_load;

    // Handshake: the result register loads when empty or being drained.
    assign step_load = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || step_load;
    assign in_load   = i_valid && o_ready;
    assign o_valid   = r_out_valid;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lines_per_job <= LINES_PER_JOB_RST;
            r_cfg.travel_max    <= TRAVEL_MAX_RST;
            r_cfg.feed_per_line <= FEED_PER_LINE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LINES_PER_JOB: r_cfg.lines_per_job <= i_cfg_data;
                CFG_TRAVEL_MAX:    r_cfg.travel_max    <= i_cfg_data;
                CFG_FEED_PER_LINE: r_cfg.feed_per_line <= i_cfg_data;
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_events.start_press  <= i_start_press;
            r_events.stop_press   <= i_stop_press;
            r_events.cover_toggle <= i_cover_toggle;
            r_events.ink_low      <= i_ink_low;
            r_events.media_empty  <= i_media_empty;
        end
    end

    // Step logic.
    pcs_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .i_events  (r_events),
        .i_cfg     (r_cfg),
        .i_state   (r_state),
        .i_pos     (r_pos),
        .i_feed    (r_feed),
        .i_printed (r_printed),
        .i_total   (r_total),
        .i_flags   (r_flags),
        .o_state   (n_state),
        .o_pos     (n_pos),
        .o_feed    (n_feed),
        .o_printed (n_printed),
        .o_total   (n_total),
        .o_flags   (n_flags),
        .o_done    (n_done)
    );

    // Sequencer state, updated once per request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pos     <= '0;
            r_feed    <= '0;
            r_printed <= '0;
            r_total   <= '0;
            r_flags   <= '0;
        end else if (step_load) begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_feed    <= n_feed;
            r_printed <= n_printed;
            r_total   <= n_total;
            r_flags   <= n_flags;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_load) begin
            o_state_code   <= n_state;
            o_position_out <= n_pos;
            o_feed_out     <= 8'(n_feed);
            o_printed_out  <= 8'(n_printed);
            o_total_out    <= 8'(n_total);
            o_flags_out    <= n_flags;
            o_job_done     <= n_done;
        end
    end

`ifndef NO_ASSERTIONS
    // A finished job always lands in idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_job_done |-> o_state_code == ST_IDLE)
        else $error("job done reported outside idle");

    // A standing media, ink or cover error keeps the machine halted.
    a_error_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && ((o_flags_out & FAULT_FLAGS) != '0) |-> o_state_code == ST_HALT)
        else $error("error flag set while not halted");

    // The reported state and position match the stored state after a step.
    a_result_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_load && i_rst_n |=> o_state_code == r_state && o_position_out == r_pos)
        else $error("result disagrees with stored state");
`endif

endmodule
